// File: design/ptu_pkg.sv
// ptu_pkg: shared types and constants for the particle table update block.
// Holds item structs, the particle record, pipeline records and cell controls.
// No dependencies.
package ptu_pkg;

  localparam int CAPACITY  = 64;
  localparam int IDX_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int NLANE     = 5;   // lane 0 scale, lanes 1..4 color R,G,B,A
  localparam int DIV_STEPS = 16;

  localparam logic [1:0] KIND_ADD    = 2'd0;
  localparam logic [1:0] KIND_VERTEX = 2'd1;
  localparam logic [1:0] KIND_EMPTY  = 2'd2;

  localparam logic REQ_ADD  = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [15:0] life_frames;
    logic [47:0] start_pos;
    logic [47:0] start_vel;
    logic [47:0] accel;
    logic [31:0] scale_pair;
    logic [31:0] color_begin;
    logic [31:0] color_end;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic        accepted;
    logic [47:0] vertex_pos;
    logic [15:0] vertex_scale;
    logic [31:0] vertex_color;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [15:0] life;
    logic [15:0] age;
    logic [47:0] pos;
    logic [47:0] vel;
    logic [47:0] acc;
    logic [31:0] scale;   // end in 31:16, start in 15:0
    logic [63:0] color;   // end in 63:32, begin in 31:0
  } particle_t;

  typedef struct packed {
    logic        add;
    logic        step;
    logic        wr;
  } cell_ctl_t;

  typedef struct packed {
    logic        valid;
    logic [1:0]  kind;
    logic        accepted;
    logic        last;
    logic [47:0] pos;
    logic [15:0] life;
  } meta_t;

  typedef struct packed {
    meta_t                       meta;
    logic [NLANE-1:0][31:0]      ps;
    logic [NLANE-1:0][31:0]      pe;
  } prod_t;

  typedef struct packed {
    meta_t                       meta;
    logic [NLANE-1:0][15:0]      r;
    logic [NLANE-1:0][15:0]      lq;   // numerator low bits in, quotient out
  } divp_t;

endpackage

// File: design/particle_table_update_top.sv
// particle_table_update_top: particle table with add and tick requests.
// Depends on ptu_pkg, ptu_cell and ptu_div_stage.
//
// The table is a chain of CAPACITY cells, newest particle in cell 0. An add
// item shifts the chain one place toward the tail and writes the new particle
// at the head; its answer passes through the interpolation pipeline. A tick item
// walks the chain: at each scan step the head cell is examined, the chain moves
// one place toward the head, and a live particle (updated age, velocity,
// position) is written back at a moving write slot so survivors stay packed
// and in order. The scan visits each stored particle once, then a flush state
// follows. Survivors then pass through a product stage, a sum stage and a
// 16-step pipelined divider (five lanes: scale and four color channels)
// while the scan goes on, newest first, and the last vertex carries the last
// flag; a tick that leaves no particle gets an empty result. A new
// item is taken only once the scan is done and the pipeline has drained; a
// finished result may still sit in the output register. A stalled output
// stalls the scan and the pipeline together.
module particle_table_update_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  ptu_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output ptu_pkg::out_item_t out_data
);
  import ptu_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SCAN  = 3'b010,
    S_FLUSH = 3'b100
  } state_t;

  function automatic logic [47:0] vec_add_sat(input logic [47:0] a,
                                              input logic [47:0] b);
    logic [47:0] r;
    logic signed [16:0] s;
    r = '0;
    for (int k = 0; k < 3; k++) begin
      s = 17'(signed'(a[16*k +: 16])) + 17'(signed'(b[16*k +: 16]));
      if (s > 17'sd32767) begin
        r[16*k +: 16] = 16'h7FFF;
      end else if (s < -17'sd32768) begin
        r[16*k +: 16] = 16'h8000;
      end else begin
        r[16*k +: 16] = s[15:0];
      end
    end
    return r;
  endfunction

  state_t            state;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  remain;
  logic [CNT_W-1:0]  kept;
  logic [IDX_W-1:0]  wptr;

  particle_t         cell_q [CAPACITY];
  cell_ctl_t         cell_ctl [CAPACITY];
  particle_t         new_item;
  particle_t         proc;
  particle_t         head;
  logic              surv;

  particle_t         hold;
  logic              hold_v;

  meta_t             m_meta;      // token entering the product stage
  particle_t         m_src;
  prod_t             pstage;
  divp_t             dv [DIV_STEPS+1];

  logic              adv;
  logic              accept;
  logic              pipe_busy;
  logic              do_add;
  logic              do_step;

  // Handshake and global advance
  assign adv    = !out_valid || out_ready;
  assign accept = in_valid && in_ready;

  always_comb begin
    pipe_busy = hold_v || pstage.meta.valid;
    for (int k = 0; k <= DIV_STEPS; k++) begin
      pipe_busy = pipe_busy || dv[k].meta.valid;
    end
  end

  assign in_ready = (state == S_IDLE) && !pipe_busy && adv;

  // Head particle update
  assign head = cell_q[0];
  assign surv = head.age < head.life;

  always_comb begin
    proc     = head;
    proc.age = head.age + 16'd1;
    proc.vel = vec_add_sat(head.vel, head.acc);
    proc.pos = vec_add_sat(head.pos, proc.vel);
  end

  assign new_item = '{life:  in_data.life_frames,
                      age:   16'd0,
                      pos:   in_data.start_pos,
                      vel:   in_data.start_vel,
                      acc:   in_data.accel,
                      scale: in_data.scale_pair,
                      color: {in_data.color_end, in_data.color_begin}};

  assign do_add  = accept && (in_data.req_type == REQ_ADD) &&
                   (count < CNT_W'(CAPACITY));
  assign do_step = (state == S_SCAN) && adv;

  // Cell chain
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    particle_t prev_d;
    particle_t next_d;
    if (i == 0) begin : g_head
      assign prev_d = new_item;
    end else begin : g_mid
      assign prev_d = cell_q[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign next_d = cell_q[i];
    end else begin : g_body
      assign next_d = cell_q[i+1];
    end
    assign cell_ctl[i] = '{add:  do_add,
                           step: do_step,
                           wr:   surv && (wptr == IDX_W'(i))};
    ptu_cell u_cell (
      .clk       (clk),
      .ctl       (cell_ctl[i]),
      .from_prev (prev_d),
      .from_next (next_d),
      .proc      (proc),
      .q         (cell_q[i])
    );
  end

  // Control: scan sequencing and token issue into the pipeline
  always_comb begin
    m_meta = '{valid: 1'b0, kind: KIND_VERTEX, accepted: 1'b0, last: 1'b0,
               pos: hold.pos, life: hold.life};
    m_src  = hold;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (in_data.req_type == REQ_ADD) begin
            m_meta.valid    = 1'b1;
            m_meta.kind     = KIND_ADD;
            m_meta.accepted = (count < CNT_W'(CAPACITY));
            m_meta.last     = 1'b1;
          end else if (count == '0) begin
            m_meta.valid = 1'b1;
            m_meta.kind  = KIND_EMPTY;
            m_meta.last  = 1'b1;
          end
        end
      end
      S_SCAN: begin
        m_meta.valid = surv && hold_v;
      end
      S_FLUSH: begin
        m_meta.valid = 1'b1;
        m_meta.last  = 1'b1;
        m_meta.kind  = hold_v ? KIND_VERTEX : KIND_EMPTY;
      end
      default: begin
        m_meta.valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      hold_v <= 1'b0;
      remain <= '0;
      kept   <= '0;
      wptr   <= '0;
    end else if (adv) begin
      unique case (state)
        S_IDLE: begin
          if (do_add) begin
            count <= count + 1'b1;
          end
          if (accept && (in_data.req_type == REQ_TICK) && (count != '0)) begin
            state  <= S_SCAN;
            remain <= count;
            kept   <= '0;
            wptr   <= IDX_W'(count - 1'b1);
          end
        end
        S_SCAN: begin
          if (surv) begin
            hold_v <= 1'b1;
            kept   <= kept + 1'b1;
          end else begin
            wptr <= wptr - 1'b1;
          end
          remain <= remain - 1'b1;
          if (remain == CNT_W'(1)) begin
            state <= S_FLUSH;
            count <= kept + CNT_W'(surv);
          end
        end
        S_FLUSH: begin
          hold_v <= 1'b0;
          state  <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_step && surv) begin
      hold <= proc;
    end
  end

  // Product stage: s*(L-a) and e*a per lane
  always_ff @(posedge clk) begin
    logic [15:0] lma;
    logic [15:0] sv;
    logic [15:0] ev;
    if (rst) begin
      pstage.meta.valid <= 1'b0;
    end else if (adv) begin
      pstage.meta.valid <= m_meta.valid;
    end
    if (adv) begin
      lma = m_src.life - m_src.age;
      pstage.meta.kind     <= m_meta.kind;
      pstage.meta.accepted <= m_meta.accepted;
      pstage.meta.last     <= m_meta.last;
      pstage.meta.pos      <= m_meta.pos;
      pstage.meta.life     <= m_meta.life;
      for (int j = 0; j < NLANE; j++) begin
        if (j == 0) begin
          sv = m_src.scale[15:0];
          ev = m_src.scale[31:16];
        end else begin
          sv = {8'd0, m_src.color[8*(j-1) +: 8]};
          ev = {8'd0, m_src.color[32 + 8*(j-1) +: 8]};
        end
        pstage.ps[j] <= 32'(sv) * 32'(lma);
        pstage.pe[j] <= 32'(ev) * 32'(m_src.age);
      end
    end
  end

  // Sum stage: numerator split into starting remainder and low bits
  always_ff @(posedge clk) begin
    logic [31:0] num;
    if (rst) begin
      dv[0].meta.valid <= 1'b0;
    end else if (adv) begin
      dv[0].meta.valid <= pstage.meta.valid;
    end
    if (adv) begin
      dv[0].meta.kind     <= pstage.meta.kind;
      dv[0].meta.accepted <= pstage.meta.accepted;
      dv[0].meta.last     <= pstage.meta.last;
      dv[0].meta.pos      <= pstage.meta.pos;
      dv[0].meta.life     <= pstage.meta.life;
      for (int j = 0; j < NLANE; j++) begin
        num = pstage.ps[j] + pstage.pe[j];
        dv[0].r[j]  <= num[31:16];
        dv[0].lq[j] <= num[15:0];
      end
    end
  end

  // Divider pipeline
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    ptu_div_stage u_div (
      .clk (clk),
      .rst (rst),
      .adv (adv),
      .d   (dv[k]),
      .q   (dv[k+1])
    );
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= dv[DIV_STEPS].meta.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data.result_kind <= dv[DIV_STEPS].meta.kind;
      out_data.last        <= dv[DIV_STEPS].meta.last;
      out_data.accepted    <= (dv[DIV_STEPS].meta.kind == KIND_ADD) &&
                              dv[DIV_STEPS].meta.accepted;
      if (dv[DIV_STEPS].meta.kind == KIND_VERTEX) begin
        out_data.vertex_pos   <= dv[DIV_STEPS].meta.pos;
        out_data.vertex_scale <= dv[DIV_STEPS].lq[0];
        out_data.vertex_color <= {dv[DIV_STEPS].lq[4][7:0], dv[DIV_STEPS].lq[3][7:0],
                                  dv[DIV_STEPS].lq[2][7:0], dv[DIV_STEPS].lq[1][7:0]};
      end else begin
        out_data.vertex_pos   <= '0;
        out_data.vertex_scale <= '0;
        out_data.vertex_color <= '0;
      end
    end
  end

endmodule

// File: design/ptu_cell.sv
// ptu_cell: one particle slot of the table chain.
// Shifts toward the tail on add; on tick steps it shifts toward the head or takes the updated particle.
// Depends on ptu_pkg.
module ptu_cell (
  input  logic               clk,
  input  ptu_pkg::cell_ctl_t ctl,
  input  ptu_pkg::particle_t from_prev,
  input  ptu_pkg::particle_t from_next,
  input  ptu_pkg::particle_t proc,
  output ptu_pkg::particle_t q
);
  import ptu_pkg::*;

  always_ff @(posedge clk) begin
    priority if (ctl.add) begin
      q <= from_prev;
    end else if (ctl.step) begin
      q <= ctl.wr ? proc : from_next;
    end
  end

endmodule

// File: design/ptu_div_stage.sv
// ptu_div_stage: one restoring-division step for all interpolation lanes,
// registered. Depends on ptu_pkg.
module ptu_div_stage (
  input  logic           clk,
  input  logic           rst,
  input  logic           adv,
  input  ptu_pkg::divp_t d,
  output ptu_pkg::divp_t q
);
  import ptu_pkg::*;

  divp_t nxt;
  logic [16:0] t;
  logic [16:0] diff;
  logic        ge;

  always_comb begin
    nxt = d;
    t = '0;
    diff = '0;
    ge = 1'b0;
    for (int j = 0; j < NLANE; j++) begin
      t    = {d.r[j], d.lq[j][15]};
      diff = t - {1'b0, d.meta.life};
      ge   = (t >= {1'b0, d.meta.life});
      nxt.r[j]  = ge ? diff[15:0] : t[15:0];
      nxt.lq[j] = {d.lq[j][14:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.meta.valid <= 1'b0;
    end else if (adv) begin
      q.meta.valid <= nxt.meta.valid;
    end
    if (adv) begin
      q.meta.kind     <= nxt.meta.kind;
      q.meta.accepted <= nxt.meta.accepted;
      q.meta.last     <= nxt.meta.last;
      q.meta.pos      <= nxt.meta.pos;
      q.meta.life     <= nxt.meta.life;
      q.r             <= nxt.r;
      q.lq            <= nxt.lq;
    end
  end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// testbench: random and directed check of particle_table_update_top.
// Holds a particle table predictor, a driver and a monitor; depends on ptu_pkg.
module testbench;
  import ptu_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  particle_table_update_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  // Predictor copy of the particle table, oldest entry at index 0.
  particle_t table_q[$];
  out_item_t vertex_expect_q[$];
  in_item_t  request_q[$];
  int        error_count;
  bit        stim_done;
  bit        calm;       // no idling in the closing stretch
  int        idle_cycles;

  function automatic logic [47:0] sat_add3(logic [47:0] a, logic [47:0] b);
    logic [47:0] r;
    int s;
    for (int k = 0; k < 3; k++) begin
      s = int'($signed(a[16*k +: 16])) + int'($signed(b[16*k +: 16]));
      if (s > 32767) s = 32767;
      if (s < -32768) s = -32768;
      r[16*k +: 16] = s[15:0];
    end
    return r;
  endfunction

  function automatic logic [15:0] blend(logic [15:0] s, logic [15:0] e,
                                        logic [15:0] a, logic [15:0] l);
    longint unsigned num;
    num = longint'(s) * longint'(l - a) + longint'(e) * longint'(a);
    return 16'(num / longint'(l));
  endfunction

  // Works out every result one accepted request causes.
  task automatic predict_request(in_item_t req);
    particle_t p, kept[$];
    out_item_t r;
    logic [15:0] age;
    logic [15:0] bc;
    r = '0;
    r.last = 1'b1;
    if (req.req_type == REQ_ADD) begin
      r.result_kind = KIND_ADD;
      if (table_q.size() < CAPACITY) begin
        p.life = req.life_frames;
        p.age = '0;
        p.pos = req.start_pos;
        p.vel = req.start_vel;
        p.acc = req.accel;
        p.scale = req.scale_pair;
        p.color = {req.color_end, req.color_begin};
        table_q.push_back(p);
        r.accepted = 1'b1;
      end
      vertex_expect_q.push_back(r);
      return;
    end
    foreach (table_q[i]) if (table_q[i].age < table_q[i].life) kept.push_back(table_q[i]);
    table_q = kept;
    if (table_q.size() == 0) begin
      r.result_kind = KIND_EMPTY;
      vertex_expect_q.push_back(r);
      return;
    end
    for (int i = table_q.size() - 1; i >= 0; i--) begin
      p = table_q[i];
      age = p.age + 16'd1;
      p.age = age;
      p.vel = sat_add3(p.vel, p.acc);
      p.pos = sat_add3(p.pos, p.vel);
      table_q[i] = p;
      r = '0;
      r.result_kind = KIND_VERTEX;
      r.vertex_pos = p.pos;
      r.vertex_scale = blend(p.scale[15:0], p.scale[31:16], age, p.life);
      for (int c = 0; c < 4; c++) begin
        bc = blend(16'(p.color[8*c +: 8]), 16'(p.color[32+8*c +: 8]), age, p.life);
        r.vertex_color[8*c +: 8] = bc[7:0];
      end
      r.last = (i == 0);
      vertex_expect_q.push_back(r);
    end
  endtask

  function automatic in_item_t rand_add(int life_hi);
    in_item_t a;
    a.req_type = REQ_ADD;
    a.life_frames = 16'($urandom_range(life_hi));
    a.start_pos = 48'({$urandom, $urandom});
    a.start_vel = 48'({$urandom, $urandom});
    a.accel = 48'({$urandom, $urandom});
    a.scale_pair = $urandom;
    a.color_begin = $urandom;
    a.color_end = $urandom;
    return a;
  endfunction

  function automatic in_item_t tick_req();
    in_item_t t;
    t = '0;
    t.req_type = REQ_TICK;
    return t;
  endfunction

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Request list: directed corners first, then random traffic.
  initial begin
    in_item_t a;
    request_q.push_back(tick_req());              // empty table tick
    a = '0; a.life_frames = 16'd0;                // zero life, never drawn
    request_q.push_back(a);
    a = '1; a.req_type = REQ_ADD;                 // all ones fields
    request_q.push_back(a);
    a = '0; a.life_frames = 16'd3;                // saturation toward max
    a.start_pos = {3{16'h7ff0}}; a.start_vel = {3{16'h0100}};
    a.accel = {3{16'h7fff}}; a.scale_pair = 32'hffff_0000;
    a.color_begin = 32'h00ff_00ff; a.color_end = 32'hff00_ff00;
    request_q.push_back(a);
    a.start_pos = {3{16'h8010}}; a.start_vel = {3{16'hff00}};
    a.accel = {3{16'h8000}}; a.life_frames = 16'd1;
    request_q.push_back(a);
    repeat (4) request_q.push_back(tick_req());   // expiries; the all-ones particle stays
    for (int i = 0; i < 66; i++) request_q.push_back(rand_add(8)); // full table
    request_q.push_back(tick_req());
    request_q.push_back(tick_req());
    for (int i = 0; i < 10; i++) request_q.push_back(tick_req()); // drain
    // Random part: mostly adds with short or long lives, ticks now and then.
    for (int i = 0; i < 130; i++) begin
      if ($urandom_range(3) == 0) request_q.push_back(tick_req());
      else request_q.push_back(rand_add($urandom_range(1) ? 12 : 65535));
    end
    request_q.push_back(tick_req());
  end

  // Driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_data <= '0;
      idle_cycles <= 0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) predict_request(in_data);
      if (idle_cycles > 0) begin
        idle_cycles <= idle_cycles - 1;
        in_valid <= 1'b0;
      end else if (request_q.size() > 0) begin
        if (!calm && $urandom_range(4) == 0) begin
          idle_cycles <= $urandom_range(1, 9) - 1;
          in_valid <= 1'b0;
        end else begin
          in_data <= request_q.pop_front();
          in_valid <= 1'b1;
        end
      end else begin
        in_valid <= 1'b0;
        stim_done <= 1'b1;
      end
    end
  end

  int stall_cycles;

  // Monitor and output stall pattern
  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      out_ready <= 1'b0;
      stall_cycles <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (vertex_expect_q.size() == 0) begin
          $display("%0t unexpected result: expected none, actual %h", $time, out_data);
          error_count++;
        end else begin
          want = vertex_expect_q.pop_front();
          if (want.result_kind !== out_data.result_kind ||
              want.accepted !== out_data.accepted ||
              want.vertex_pos !== out_data.vertex_pos ||
              want.vertex_scale !== out_data.vertex_scale ||
              want.vertex_color !== out_data.vertex_color ||
              want.last !== out_data.last) begin
            $display("%0t mismatch: expected %h, actual %h", $time, want, out_data);
            error_count++;
          end
        end
      end
      if (stall_cycles > 0) begin
        stall_cycles <= stall_cycles - 1;
        out_ready <= 1'b0;
      end else if (!calm && $urandom_range(5) == 0) begin
        stall_cycles <= $urandom_range(1, 9) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles with no handshake on either side.
  int quiet_cycles;
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    rst = 1'b1;
    error_count = 0;
    stim_done = 1'b0;
    calm = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    while (!(stim_done && vertex_expect_q.size() == 0) && quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (request_q.size() < 30) calm = 1'b1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      repeat (100) @(posedge clk);   // catch stray results
      if (error_count == 0 && vertex_expect_q.size() == 0)
        $display("[ OK ] regression clean");
      else
        $display("[FAIL] regression broken");
      $finish;
    end
  end
endmodule
